/* src/smn_pkg.sv */
// Package for the slice maximum finder and 8-bit normalizer.
// Holds widths, register indexes and the word carried along the divider cells.
// No dependencies.
`default_nettype none

package smn_pkg;

	localparam int PIX_FIELD_BITS = 16;
	localparam int DIV_BITS       = 16;
	localparam int LEVEL_BITS     = 8;
	localparam int REM_BITS       = DIV_BITS + LEVEL_BITS;
	localparam int CFG_BITS       = 16;
	localparam int CFG_IDX_BITS   = 1;

	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_CEILING   = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_REFERENCE_MAX = 1'd1;

	localparam logic [DIV_BITS-1:0]   CEILING_RESET = 16'd2500;
	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX     = 8'd255;

	localparam logic FUNC_SCAN  = 1'b0;
	localparam logic FUNC_SCALE = 1'b1;

	typedef struct packed {
		logic [REM_BITS-1:0]   rem;
		logic [DIV_BITS-1:0]   dvs;
		logic [LEVEL_BITS-1:0] quo;
		logic                  skip;
		logic                  zero;
		logic                  last;
	} smn_work_t;

endpackage

`default_nettype wire

/* src/smn_if.sv */
// Stream interfaces of the slice normalizer: pixel words in, level words out.
// Depends on smn_pkg for field widths.
`default_nettype none

interface smn_pix_if;
	logic                                valid;
	logic                                ready;
	logic                                func;
	logic [smn_pkg::PIX_FIELD_BITS-1:0]  pixel;
	logic                                first;
	logic                                last;

	modport source(output valid, func, pixel, first, last, input ready);
	modport sink(input valid, func, pixel, first, last, output ready);
endinterface

interface smn_lvl_if;
	logic                            valid;
	logic                            ready;
	logic [smn_pkg::LEVEL_BITS-1:0]  level;
	logic                            end_of_slice;
	logic                            zero_divisor;

	modport source(output valid, level, end_of_slice, zero_divisor, input ready);
	modport sink(input valid, level, end_of_slice, zero_divisor, output ready);
endinterface

`default_nettype wire

/* src/slice_max_normalize_to_8bit_top.sv */
// Slice maximum finder and 8-bit normalizer, top level.
// Path: a scale word passes the head cell and then eight quotient cells, one bit each,
// each registered; scan words update the maximum and give no word.
// Throughput: one word per cycle; each cell holds its word only while the next one is full.
// Reset: cell valids clear, running maximum 0, max_ceiling 2500, reference_max 0.
`default_nettype none

module slice_max_normalize_to_8bit_top #(
	parameter int PIXEL_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	smn_pix_if.sink                                 pix,
	smn_lvl_if.source                               lvl,
	input  wire logic                               cfg_we,
	input  wire logic [smn_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [smn_pkg::CFG_BITS-1:0]       cfg_data
);

	localparam int NCELL = smn_pkg::LEVEL_BITS;

	logic [smn_pkg::DIV_BITS-1:0] max_ceiling_q;
	logic [smn_pkg::DIV_BITS-1:0] reference_max_q;
	logic [PIXEL_BITS-1:0]        running_max_q;
	logic [PIXEL_BITS-1:0]        pix_m;
	logic [PIXEL_BITS-1:0]        scan_base;
	logic [smn_pkg::DIV_BITS-1:0] pix_ext;
	logic [smn_pkg::DIV_BITS-1:0] divisor;
	logic                         acc;
	logic                         front_ready;

	logic               stage_valid [NCELL+1];
	logic               stage_ready [NCELL+1];
	smn_pkg::smn_work_t stage_work  [NCELL+1];

	assign pix_m     = pix.pixel[PIXEL_BITS-1:0];
	assign pix_ext   = smn_pkg::DIV_BITS'(pix_m);
	assign pix.ready = front_ready;
	assign acc       = pix.valid && front_ready;
	assign scan_base = pix.first ? '0 : running_max_q;
	assign divisor   = (reference_max_q != '0) ? reference_max_q
	                                           : smn_pkg::DIV_BITS'(running_max_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_ceiling_q   <= smn_pkg::CEILING_RESET;
			reference_max_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				smn_pkg::REG_MAX_CEILING:   max_ceiling_q   <= cfg_data;
				smn_pkg::REG_REFERENCE_MAX: reference_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The scan updates at acceptance, so a later scale word sees every earlier scan word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_max_q <= '0;
		end else if (acc && pix.func == smn_pkg::FUNC_SCAN) begin
			if (pix_m > scan_base && pix_ext < max_ceiling_q) begin
				running_max_q <= pix_m;
			end else begin
				running_max_q <= scan_base;
			end
		end
	end

	smn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix.valid && pix.func == smn_pkg::FUNC_SCALE),
		.in_ready  (front_ready),
		.pix       (pix_ext),
		.dvs       (divisor),
		.last      (pix.last),
		.out_valid (stage_valid[0]),
		.out_ready (stage_ready[0]),
		.out_work  (stage_work[0])
	);

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		smn_cell #(
			.STEP(NCELL - 1 - g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stage_valid[g]),
			.in_ready  (stage_ready[g]),
			.in_work   (stage_work[g]),
			.out_valid (stage_valid[g+1]),
			.out_ready (stage_ready[g+1]),
			.out_work  (stage_work[g+1])
		);
	end

	assign stage_ready[NCELL] = lvl.ready;
	assign lvl.valid          = stage_valid[NCELL];
	assign lvl.level          = stage_work[NCELL].quo;
	assign lvl.end_of_slice   = stage_work[NCELL].last;
	assign lvl.zero_divisor   = stage_work[NCELL].zero;

	// A zero divisor must come out as level zero.
	a_zero_level: assert property (@(posedge clk) disable iff (!arst_n)
		lvl.valid && lvl.zero_divisor |-> lvl.level == '0)
		else $error("zero divisor with nonzero level");

	// Within a scan pass the maximum never falls.
	a_max_grows: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pix.func == smn_pkg::FUNC_SCAN && !pix.first
		|=> running_max_q >= $past(running_max_q))
		else $error("running maximum fell during a scan pass");

	// A first scan word of zero restarts the maximum at zero.
	a_max_restart: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pix.func == smn_pkg::FUNC_SCAN && pix.first && pix_m == '0
		|=> running_max_q == '0)
		else $error("running maximum not restarted");

	// A scan word never enters the divider chain.
	a_scan_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pix.func == smn_pkg::FUNC_SCAN && !stage_valid[0] |=> !stage_valid[0])
		else $error("scan word entered the divider");

endmodule

`default_nettype wire

/* src/smn_front.sv */
// Head cell of the divider chain: forms pixel*255, detects saturation and
// a zero divisor, and registers the word for the first quotient cell. Uses smn_pkg.
`default_nettype none

module smn_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [smn_pkg::DIV_BITS-1:0]  pix,
	input  wire logic [smn_pkg::DIV_BITS-1:0]  dvs,
	input  wire logic                          last,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output smn_pkg::smn_work_t                 out_work
);

	logic [smn_pkg::REM_BITS-1:0] prod;
	logic [smn_pkg::REM_BITS-1:0] dvs_top;
	logic                         zero;
	logic                         sat;
	smn_pkg::smn_work_t           work_d;
	smn_pkg::smn_work_t           work_q;
	logic                         valid_q;

	// pixel * 255 as (pixel << 8) - pixel.
	assign prod    = {pix, {smn_pkg::LEVEL_BITS{1'b0}}} - smn_pkg::REM_BITS'(pix);
	assign dvs_top = {dvs, {smn_pkg::LEVEL_BITS{1'b0}}};
	assign zero    = (dvs == '0);
	// The quotient reaches 256 exactly when the product is at least divisor << 8.
	assign sat     = !zero && (prod >= dvs_top);

	always_comb begin
		work_d.rem  = prod;
		work_d.dvs  = dvs;
		work_d.quo  = sat ? smn_pkg::LEVEL_MAX : '0;
		work_d.skip = sat || zero;
		work_d.zero = zero;
		work_d.last = last;
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			work_q <= work_d;
		end
	end

	assign out_valid = valid_q;
	assign out_work  = work_q;

endmodule

`default_nettype wire

/* src/smn_cell.sv */
// One restoring-division cell: decides quotient bit STEP and hands the
// reduced remainder to its neighbor. Uses smn_pkg.
`default_nettype none

module smn_cell #(
	parameter int STEP = 0
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire smn_pkg::smn_work_t in_work,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output smn_pkg::smn_work_t      out_work
);

	logic [smn_pkg::REM_BITS-1:0] shifted;
	logic                         hit;
	smn_pkg::smn_work_t           work_d;
	smn_pkg::smn_work_t           work_q;
	logic                         valid_q;

	assign shifted = smn_pkg::REM_BITS'(in_work.dvs) << STEP;
	assign hit     = !in_work.skip && (in_work.rem >= shifted);

	always_comb begin
		work_d = in_work;
		if (hit) begin
			work_d.rem       = in_work.rem - shifted;
			work_d.quo[STEP] = 1'b1;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			work_q <= work_d;
		end
	end

	assign out_valid = valid_q;
	assign out_work  = work_q;

endmodule

`default_nettype wire

/* dv/slice_max_normalize_to_8bit_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for slice_max_normalize_to_8bit_top: scan and scale passes,
// random idling on both streams, register settings changed between drained phases.
// Depends on smn_pkg, smn_if and the top level from src.

module slice_max_normalize_to_8bit_top_tb;

	localparam int PIXEL_BITS = 16;
	localparam logic [smn_pkg::PIX_FIELD_BITS-1:0] PIXEL_MASK =
		smn_pkg::PIX_FIELD_BITS'({PIXEL_BITS{1'b1}});
	// Quiet cycles on both streams before a register write.
	localparam int SETTLE_CYCLES = 14;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 75;

	typedef struct {
		logic [smn_pkg::LEVEL_BITS-1:0] level;
		logic                           end_of_slice;
		logic                           zero_divisor;
	} level_word_t;

	class level_scoreboard;
		logic [smn_pkg::CFG_BITS-1:0]  ceiling;
		logic [smn_pkg::CFG_BITS-1:0]  ref_max;
		logic [smn_pkg::DIV_BITS-1:0]  running_max;
		level_word_t                   pending_levels[$];
		int unsigned                   errors;
		int unsigned                   levels_seen;
		int unsigned                   zero_seen;
		int unsigned                   sat_seen;

		function new();
			ceiling = smn_pkg::CEILING_RESET;
			ref_max = '0;
			running_max = '0;
			errors = 0;
			levels_seen = 0;
			zero_seen = 0;
			sat_seen = 0;
		endfunction

		function void write_reg(logic [smn_pkg::CFG_IDX_BITS-1:0] idx,
				logic [smn_pkg::CFG_BITS-1:0] data);
			if (idx == smn_pkg::REG_MAX_CEILING) begin
				ceiling = data;
			end else if (idx == smn_pkg::REG_REFERENCE_MAX) begin
				ref_max = data;
			end
		endfunction

		// Apply one accepted pixel word; scale words queue the level they must produce.
		function void note_pixel(logic func, logic [smn_pkg::PIX_FIELD_BITS-1:0] raw,
				logic first, logic last);
			logic [smn_pkg::PIX_FIELD_BITS-1:0] pixel;
			logic [smn_pkg::DIV_BITS-1:0]       divisor;
			logic [31:0]                        scaled;
			level_word_t                        w;
			pixel = raw & PIXEL_MASK;
			if (func == smn_pkg::FUNC_SCAN) begin
				if (first)
					running_max = '0;
				if (pixel > running_max && pixel < ceiling)
					running_max = pixel;
				return;
			end
			divisor = (ref_max != '0) ? ref_max : running_max;
			w.end_of_slice = last;
			if (divisor == '0) begin
				w.level = '0;
				w.zero_divisor = 1'b1;
				zero_seen++;
			end else begin
				scaled = (32'(pixel) * 32'(smn_pkg::LEVEL_MAX)) / 32'(divisor);
				if (scaled > 32'(smn_pkg::LEVEL_MAX)) begin
					w.level = smn_pkg::LEVEL_MAX;
					sat_seen++;
				end else begin
					w.level = scaled[smn_pkg::LEVEL_BITS-1:0];
				end
				w.zero_divisor = 1'b0;
			end
			pending_levels.insert(pending_levels.size(), w);
		endfunction

		function void check_level(logic [smn_pkg::LEVEL_BITS-1:0] level, logic eos, logic zd);
			level_word_t w;
			levels_seen++;
			if (pending_levels.size() == 0) begin
				$display("%0t: unexpected level word level=%0d end_of_slice=%0b zero_divisor=%0b",
					$time, level, eos, zd);
				errors++;
				return;
			end
			w = pending_levels.pop_front();
			if (level !== w.level) begin
				$display("%0t: level expected %0d actual %0d", $time, w.level, level);
				errors++;
			end
			if (eos !== w.end_of_slice) begin
				$display("%0t: end_of_slice expected %0b actual %0b", $time,
					w.end_of_slice, eos);
				errors++;
			end
			if (zd !== w.zero_divisor) begin
				$display("%0t: zero_divisor expected %0b actual %0b", $time,
					w.zero_divisor, zd);
				errors++;
			end
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_we;
	logic [smn_pkg::CFG_IDX_BITS-1:0] cfg_index;
	logic [smn_pkg::CFG_BITS-1:0]     cfg_data;
	bit                               idle_on;
	int unsigned                      pixels_sent;
	int unsigned                      scans_sent;
	int unsigned                      reg_writes;
	level_scoreboard                  sb;

	smn_pix_if pix_bus();
	smn_lvl_if lvl_bus();

	slice_max_normalize_to_8bit_top #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_bus),
		.lvl(lvl_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic send_pixel(logic func, logic [smn_pkg::PIX_FIELD_BITS-1:0] pixel,
			logic first, logic last);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			pix_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		pix_bus.valid <= 1'b1;
		pix_bus.func <= func;
		pix_bus.pixel <= pixel;
		pix_bus.first <= first;
		pix_bus.last <= last;
		do @(posedge clk); while (pix_bus.ready !== 1'b1);
		sb.note_pixel(func, pixel, first, last);
		pixels_sent++;
		if (func == smn_pkg::FUNC_SCAN)
			scans_sent++;
	endtask

	// Hold the pixel stream until every level word is out and the streams are quiet.
	task automatic drain();
		pix_bus.valid <= 1'b0;
		while (sb.pending_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [smn_pkg::CFG_IDX_BITS-1:0] idx,
			logic [smn_pkg::CFG_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
		reg_writes++;
	endtask

	function automatic logic [smn_pkg::PIX_FIELD_BITS-1:0] pick_pixel();
		logic [smn_pkg::PIX_FIELD_BITS-1:0] c;
		c = sb.ceiling;
		case ($urandom_range(0, 7))
			0: return smn_pkg::PIX_FIELD_BITS'($urandom_range(0, 65535));
			1, 2: return (c == '0) ? '0 : smn_pkg::PIX_FIELD_BITS'($urandom_range(0, c - 1));
			3: return c;
			4: return c - 1'b1;
			5: return '0;
			6: return '1;
			default: return smn_pkg::PIX_FIELD_BITS'($urandom_range(0, 255));
		endcase
	endfunction

	// One slice: a scan pass framed by first and last, then a scale pass.
	task automatic run_slice();
		int n_scan;
		int n_scale;
		n_scan = $urandom_range(1, 12);
		n_scale = $urandom_range(1, 12);
		for (int i = 0; i < n_scan; i++)
			send_pixel(smn_pkg::FUNC_SCAN, pick_pixel(), i == 0, i == n_scan - 1);
		for (int i = 0; i < n_scale; i++)
			send_pixel(smn_pkg::FUNC_SCALE, pick_pixel(), i == 0, i == n_scale - 1);
	endtask

	initial begin
		int unsigned start;
		sb = new();
		pixels_sent = 0;
		scans_sent = 0;
		reg_writes = 0;
		idle_on = 1'b1;
		arst_n <= 1'b0;
		pix_bus.valid <= 1'b0;
		pix_bus.func <= smn_pkg::FUNC_SCAN;
		pix_bus.pixel <= '0;
		pix_bus.first <= 1'b0;
		pix_bus.last <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= smn_pkg::REG_MAX_CEILING;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: scaling before any scan must see a zero divisor.
		send_pixel(smn_pkg::FUNC_SCALE, 16'd1000, 1'b1, 1'b1);
		send_pixel(smn_pkg::FUNC_SCAN, 16'd0, 1'b1, 1'b0);
		send_pixel(smn_pkg::FUNC_SCAN, 16'hFFFF, 1'b0, 1'b0);
		send_pixel(smn_pkg::FUNC_SCAN, smn_pkg::CEILING_RESET, 1'b0, 1'b0);
		send_pixel(smn_pkg::FUNC_SCAN, smn_pkg::CEILING_RESET - 1'b1, 1'b0, 1'b1);
		send_pixel(smn_pkg::FUNC_SCALE, 16'd0, 1'b1, 1'b0);
		send_pixel(smn_pkg::FUNC_SCALE, smn_pkg::CEILING_RESET - 1'b1, 1'b0, 1'b0);
		send_pixel(smn_pkg::FUNC_SCALE, 16'hFFFF, 1'b1, 1'b0);
		send_pixel(smn_pkg::FUNC_SCALE, 16'd1249, 1'b0, 1'b1);
		// A scan continued without first keeps the larger maximum.
		send_pixel(smn_pkg::FUNC_SCAN, 16'd2000, 1'b1, 1'b0);
		send_pixel(smn_pkg::FUNC_SCAN, 16'd100, 1'b0, 1'b1);
		send_pixel(smn_pkg::FUNC_SCALE, 16'd1000, 1'b1, 1'b1);

		drain();
		write_reg(smn_pkg::REG_MAX_CEILING, 16'd0);
		send_pixel(smn_pkg::FUNC_SCAN, 16'd0, 1'b1, 1'b0);
		send_pixel(smn_pkg::FUNC_SCAN, 16'hFFFF, 1'b0, 1'b1);
		send_pixel(smn_pkg::FUNC_SCALE, 16'd5, 1'b1, 1'b1);

		drain();
		write_reg(smn_pkg::REG_MAX_CEILING, 16'hFFFF);
		write_reg(smn_pkg::REG_REFERENCE_MAX, 16'hFFFF);
		send_pixel(smn_pkg::FUNC_SCALE, 16'hFFFF, 1'b1, 1'b0);
		send_pixel(smn_pkg::FUNC_SCALE, 16'd0, 1'b0, 1'b0);
		send_pixel(smn_pkg::FUNC_SCALE, 16'd1, 1'b0, 1'b1);

		drain();
		write_reg(smn_pkg::REG_REFERENCE_MAX, 16'd1);
		send_pixel(smn_pkg::FUNC_SCALE, 16'd1, 1'b1, 1'b0);
		send_pixel(smn_pkg::FUNC_SCALE, 16'd0, 1'b0, 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: begin
					write_reg(smn_pkg::REG_MAX_CEILING, 16'hFFFF);
					write_reg(smn_pkg::REG_REFERENCE_MAX, 16'd0);
				end
				1: begin
					write_reg(smn_pkg::REG_MAX_CEILING, 16'd0);
					write_reg(smn_pkg::REG_REFERENCE_MAX, 16'd0);
				end
				2: begin
					write_reg(smn_pkg::REG_MAX_CEILING,
						smn_pkg::CFG_BITS'($urandom_range(0, 65535)));
					write_reg(smn_pkg::REG_REFERENCE_MAX, 16'hFFFF);
				end
				3: begin
					write_reg(smn_pkg::REG_MAX_CEILING,
						smn_pkg::CFG_BITS'($urandom_range(1, 300)));
					write_reg(smn_pkg::REG_REFERENCE_MAX, 16'd1);
				end
				default: begin
					write_reg(smn_pkg::REG_MAX_CEILING, ($urandom_range(0, 1) == 0) ?
						smn_pkg::CFG_BITS'($urandom_range(0, 65535)) :
						smn_pkg::CFG_BITS'($urandom_range(1, 6000)));
					write_reg(smn_pkg::REG_REFERENCE_MAX, ($urandom_range(0, 2) == 0) ?
						smn_pkg::CFG_BITS'($urandom_range(0, 65535)) : 16'd0);
				end
			endcase
			start = pixels_sent;
			while (pixels_sent - start < ITEMS_PER_PHASE) begin
				idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 6) == 0) begin
					repeat ($urandom_range(1, 4))
						send_pixel(1'($urandom_range(0, 1)),
							smn_pkg::PIX_FIELD_BITS'($urandom_range(0, 65535)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end else begin
					run_slice();
				end
			end
		end

		drain();
		$display("Sent %0d pixel words (%0d scan), %0d register writes, %0d level words checked.",
			pixels_sent, scans_sent, reg_writes, sb.levels_seen);
		$display("Level words with zero divisor: %0d, saturated at the top level: %0d.",
			sb.zero_seen, sb.sat_seen);
		if (sb.errors == 0 && sb.pending_levels.size() == 0) begin
			$display("slice_max_normalize_to_8bit_top regression: pass");
		end else begin
			$display("slice_max_normalize_to_8bit_top regression: fail");
		end
		$finish;
	end

	// Level stream receiver with random stall bursts.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		lvl_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && lvl_bus.valid === 1'b1 && lvl_bus.ready === 1'b1)
				sb.check_level(lvl_bus.level, lvl_bus.end_of_slice, lvl_bus.zero_divisor);
			if (stall_left > 0) begin
				stall_left--;
				lvl_bus.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				lvl_bus.ready <= 1'b0;
			end else begin
				lvl_bus.ready <= 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d level words still expected.", sb.pending_levels.size());
		$display("slice_max_normalize_to_8bit_top regression: fail");
		$finish;
	end

endmodule
